@@ design/reol_pkg.sv @@
// Package for the ring entry offset lookup: field widths, operation codes and sequencer states.
`default_nettype none

package reol_pkg;

  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned OFS_W    = 28;

  typedef enum logic {
    FN_ADD  = 1'b0,
    FN_FIND = 1'b1
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

endpackage : reol_pkg

`default_nettype wire

@@ design/ring_entry_offset_lookup_unit.sv @@
// Ring of record descriptors with overwrite, and a sequential lookup by character offset.
//
// Use: a request on the in_ channel either adds a descriptor (in_func add) or looks up a
// character offset (in_func find). An add gives no result. A find gives one result on the
// out_ channel: found flag, handle of the record holding the offset and the byte position
// inside it, all zero when the offset lies beyond the data.
// Timing: a find walks the stored lengths from the oldest descriptor onward, one slot per
// cycle, through one adder and comparator and one registered read of the descriptor
// memory. The walk stops at the first slot whose running total exceeds the offset, or
// after the last slot on a miss. in_ready rises again in the cycle the result appears,
// so no new request is taken while a find walks.
// Stalls: the result waits in the output register while out_ready is low, and further
// requests are taken meanwhile; a later find that finishes its walk holds its last slot
// until the register is free.
// Reset: all descriptors read as empty (per-slot valid bits are cleared), the ring is
// empty and both slot pointers return to zero.
`default_nettype none

module ring_entry_offset_lookup_unit
  import reol_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_func,
  input  wire logic [HANDLE_W-1:0] in_new_handle,
  input  wire logic [LEN_W-1:0]    in_new_size,
  input  wire logic [OFS_W-1:0]    in_char_offset,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_found,
  output logic [HANDLE_W-1:0]      out_found_handle,
  output logic [LEN_W-1:0]         out_byte_within
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SUM_W  = LEN_W + SLOT_W;
  localparam int unsigned CMP_W  = (SUM_W > OFS_W) ? SUM_W : OFS_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Descriptor memory and per-slot valid bits
  logic [HANDLE_W-1:0] hdl_mem [SLOTS];
  logic [LEN_W-1:0]    len_mem [SLOTS];
  logic [SLOTS-1:0]    vld_r;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   write_slot_r, write_slot_nxt;
  logic [SLOT_W-1:0]   oldest_slot_r, oldest_slot_nxt;
  logic                ring_full_r, ring_full_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic [CMP_W-1:0]    total_r, total_nxt;
  logic [CMP_W-1:0]    target_r, target_nxt;

  logic [SLOT_W-1:0]   rd_addr;
  logic [HANDLE_W-1:0] rd_hdl_r;
  logic [LEN_W-1:0]    rd_len_r;
  logic                rd_vld_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [LEN_W-1:0]    out_byte_r, out_byte_nxt;

  logic                accept;
  logic                add_we;
  logic [SLOT_W-1:0]   write_next;
  logic [LEN_W-1:0]    cur_len;
  logic [CMP_W-1:0]    sum;
  logic                hit;
  logic                out_free;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  assign accept     = in_valid && in_ready;
  assign add_we     = accept && (func_t'(in_func) == FN_ADD);
  assign write_next = next_slot(write_slot_r);
  assign cur_len    = rd_vld_r ? rd_len_r : '0;
  assign sum        = total_r + CMP_W'(cur_len);
  assign hit        = sum > target_r;
  assign out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (add_we) begin
      hdl_mem[write_slot_r] <= in_new_handle;
      len_mem[write_slot_r] <= in_new_size;
    end
    rd_hdl_r <= hdl_mem[rd_addr];
    rd_len_r <= len_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (add_we) begin
        vld_r[write_slot_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      write_slot_r  <= '0;
      oldest_slot_r <= '0;
      ring_full_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      write_slot_r  <= write_slot_nxt;
      oldest_slot_r <= oldest_slot_nxt;
      ring_full_r   <= ring_full_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    total_r      <= total_nxt;
    target_r     <= target_nxt;
    out_found_r  <= out_found_nxt;
    out_handle_r <= out_handle_nxt;
    out_byte_r   <= out_byte_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    write_slot_nxt  = write_slot_r;
    oldest_slot_nxt = oldest_slot_r;
    ring_full_nxt   = ring_full_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    total_nxt       = total_r;
    target_nxt      = target_r;
    rd_addr         = idx_r;
    out_found_nxt   = out_found_r;
    out_handle_nxt  = out_handle_r;
    out_byte_nxt    = out_byte_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    in_ready        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = oldest_slot_r;
        if (add_we) begin
          write_slot_nxt = write_next;
          // Once full, the oldest slot tracks the write slot, wrap included.
          if (ring_full_r) begin
            oldest_slot_nxt = write_next;
          end else if (write_next == oldest_slot_r) begin
            ring_full_nxt = 1'b1;
          end
        end else if (accept) begin
          state_nxt  = ST_WALK;
          idx_nxt    = oldest_slot_r;
          cnt_nxt    = '0;
          total_nxt  = '0;
          target_nxt = CMP_W'(in_char_offset);
        end
      end
      ST_WALK: begin
        if (hit || cnt_r == LAST_SLOT) begin
          // The walk has its answer; hold the current slot until the output is free.
          if (out_free) begin
            state_nxt      = ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_found_nxt  = hit;
            out_handle_nxt = hit ? rd_hdl_r : '0;
            out_byte_nxt   = hit ? LEN_W'(target_r - total_r) : '0;
          end
        end else begin
          rd_addr   = next_slot(idx_r);
          idx_nxt   = next_slot(idx_r);
          cnt_nxt   = cnt_r + SLOT_W'(1);
          total_nxt = sum;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_found_handle = out_handle_r;
  assign out_byte_within  = out_byte_r;

`ifndef SYNTHESIS
  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    ring_full_r |-> write_slot_r == oldest_slot_r)
    else $error("ring full but write and oldest slots differ");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_handle_r == '0 && out_byte_r == '0))
    else $error("miss result carries non-zero fields");

  a_find_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && func_t'(in_func) == FN_FIND) |=> (state_r == ST_WALK && !in_ready))
    else $error("accepted find did not start a walk");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_WALK)
    else $error("result appeared without a walk");

  a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r && !$stable(out_byte_r)) |-> $past(cur_len) > out_byte_r)
    else $error("byte position exceeds record length");
`endif

endmodule : ring_entry_offset_lookup_unit

`default_nettype wire
